@@ design/srins_pkg.sv @@
// shared types and constants for the sorted ring insert and search block
package srins_pkg;

    localparam int VALUE_W  = 64;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 4;
    localparam int OCC_W    = 5;

    localparam logic ACTION_INSERT = 1'b0;
    localparam logic ACTION_SEARCH = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN
    } t_state;

    typedef struct packed {
        logic wr_empty;
        logic wr_append;
        logic wr_prepend;
        logic wr_mid;
        logic ld_match;
        logic sh_match;
    } t_cell_ctl;

endpackage

@@ design/srins_if.sv @@
// request and response channel interfaces
interface srins_in_if import srins_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       action;
    logic signed [VALUE_W-1:0]  value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface srins_out_if import srins_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [SLOT_W-1:0]    slot;
    logic [OCC_W-1:0]     occupancy;

    modport source (output valid, output status, output slot, output occupancy, input ready);
    modport sink   (input valid, input status, input slot, input occupancy, output ready);
endinterface

@@ design/srins_cell.sv @@
// one ring slot: compare, shift toward tail on insert, match bit shift on search
module srins_cell import srins_pkg::*; #(
    parameter int CAPACITY = 16,
    parameter int INDEX    = 0,
    parameter int PW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cell_ctl                  i_ctl,
    input  logic signed [VALUE_W-1:0]  i_key,
    input  logic [PW-1:0]              i_head,
    input  logic [CW-1:0]              i_count,
    input  logic signed [VALUE_W-1:0]  i_pred_val,
    input  logic                       i_pred_gt,
    input  logic                       i_next_match,
    output logic signed [VALUE_W-1:0]  o_val,
    output logic                       o_gt,
    output logic                       o_match
);

    localparam logic [PW-1:0] IDX  = PW'(INDEX);
    localparam logic [PW-1:0] LAST = PW'(CAPACITY - 1);
    localparam logic [PW:0]   CAP  = (PW + 1)'(CAPACITY);

    logic signed [VALUE_W-1:0] r_val;
    logic                      r_match;
    logic [PW-1:0]             w_off;
    logic [CW-1:0]             w_offc;
    logic                      w_occ;
    logic                      w_gt;
    logic                      w_wr;
    logic signed [VALUE_W-1:0] w_wdata;

    // ring offset of this slot from the head
    always_comb begin
        if (i_head <= IDX) begin
            w_off = IDX - i_head;
        end else begin
            w_off = PW'(({1'b0, IDX} + CAP) - {1'b0, i_head});
        end
        w_offc = CW'(w_off);
        w_occ  = w_offc < i_count;
        w_gt   = w_occ && (r_val > i_key);
        w_wr   = (i_ctl.wr_empty && (w_off == '0))
              || (i_ctl.wr_append && (w_offc == i_count))
              || (i_ctl.wr_prepend && (w_off == LAST))
              || (i_ctl.wr_mid && (w_gt || (w_offc == i_count)));
        w_wdata = (i_ctl.wr_mid && i_pred_gt) ? i_pred_val : i_key;
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_val <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_ctl.ld_match) begin
            r_match <= w_occ && (r_val == i_key);
        end else if (i_ctl.sh_match) begin
            r_match <= i_next_match;
        end
    end

    assign o_val   = r_val;
    assign o_gt    = w_gt;
    assign o_match = r_match;

endmodule

@@ design/sorted_ring_insert_search_top.sv @@
// sorted ring of signed keys with insert and lowest-slot search
// insert: after capture, the execute step registers the result once the output is free
// search: the execute step loads the match bits, then the scan moves them toward slot 0 until the
//         lowest matching slot or the last slot; an empty search answers from the execute step
// throughput: a new request is taken only after the previous result is registered; searches are
//             bounded by the match bit walk down the cell chain, one slot per cycle
// reset: head, count and control clear; slot contents are not reset
module sorted_ring_insert_search_top import srins_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    srins_in_if.sink     i_req,
    srins_out_if.source  o_rsp
);

    localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [PW-1:0] LAST = PW'(CAPACITY - 1);
    localparam logic [CW-1:0] FULL = CW'(CAPACITY);

    t_state                    r_state, n_state;
    logic                      r_action;
    logic signed [VALUE_W-1:0] r_key;
    logic signed [VALUE_W-1:0] r_min, n_min;
    logic signed [VALUE_W-1:0] r_max, n_max;
    logic [PW-1:0]             r_head, n_head;
    logic [CW-1:0]             r_count, n_count;
    logic [PW-1:0]             r_idx, n_idx;
    logic                      r_out_valid, n_out_valid;
    logic [STATUS_W-1:0]       r_status, n_status;
    logic [SLOT_W-1:0]         r_slot, n_slot;
    logic [OCC_W-1:0]          r_occ, n_occ;

    t_cell_ctl                 w_ctl;
    logic                      w_out_free;
    logic                      w_load_out;
    logic                      w_found;
    logic [CW+OCC_W-1:0]       w_occ_ext;
    logic [PW+SLOT_W-1:0]      w_slot_ext;

    logic signed [VALUE_W-1:0] w_val   [CAPACITY];
    logic                      w_gt    [CAPACITY];
    logic                      w_match [CAPACITY];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        localparam int PRED = (g == 0) ? CAPACITY - 1 : g - 1;
        logic w_next_match;
        if (g == CAPACITY - 1) begin : g_end
            assign w_next_match = 1'b0;
        end else begin : g_mid
            assign w_next_match = w_match[g + 1];
        end
        srins_cell #(
            .CAPACITY (CAPACITY),
            .INDEX    (g),
            .PW       (PW),
            .CW       (CW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_key        (r_key),
            .i_head       (r_head),
            .i_count      (r_count),
            .i_pred_val   (w_val[PRED]),
            .i_pred_gt    (w_gt[PRED]),
            .i_next_match (w_next_match),
            .o_val        (w_val[g]),
            .o_gt         (w_gt[g]),
            .o_match      (w_match[g])
        );
    end

    assign w_out_free = !r_out_valid || o_rsp.ready;
    assign w_found    = w_match[0];
    assign w_occ_ext  = (CW + OCC_W)'(n_count);
    assign w_slot_ext = (PW + SLOT_W)'(r_idx);

    assign i_req.ready     = (r_state == ST_IDLE);
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.status    = r_status;
    assign o_rsp.slot      = r_slot;
    assign o_rsp.occupancy = r_occ;

    always_comb begin
        n_state    = r_state;
        n_min      = r_min;
        n_max      = r_max;
        n_head     = r_head;
        n_count    = r_count;
        n_idx      = r_idx;
        n_status   = r_status;
        n_slot     = r_slot;
        w_ctl      = '0;
        w_load_out = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (r_action == ACTION_INSERT) begin
                    if (w_out_free) begin
                        w_load_out = 1'b1;
                        n_state    = ST_IDLE;
                        n_slot     = '0;
                        priority if (r_count == FULL) begin
                            n_status = STATUS_FULL;
                        end else if (r_count == '0) begin
                            n_status        = STATUS_OK;
                            w_ctl.wr_empty  = 1'b1;
                            n_min           = r_key;
                            n_max           = r_key;
                            n_count         = r_count + 1'b1;
                        end else if (r_key >= r_max) begin
                            n_status        = STATUS_OK;
                            w_ctl.wr_append = 1'b1;
                            n_max           = r_key;
                            n_count         = r_count + 1'b1;
                        end else if (r_key < r_min) begin
                            n_status         = STATUS_OK;
                            w_ctl.wr_prepend = 1'b1;
                            n_min            = r_key;
                            n_head           = (r_head == '0) ? LAST : r_head - 1'b1;
                            n_count          = r_count + 1'b1;
                        end else begin
                            n_status     = STATUS_OK;
                            w_ctl.wr_mid = 1'b1;
                            n_count      = r_count + 1'b1;
                        end
                    end
                end else if (r_count == '0) begin
                    if (w_out_free) begin
                        w_load_out = 1'b1;
                        n_state    = ST_IDLE;
                        n_status   = STATUS_MISS;
                        n_slot     = '0;
                    end
                end else begin
                    w_ctl.ld_match = 1'b1;
                    n_idx          = '0;
                    n_state        = ST_SCAN;
                end
            end
            ST_SCAN: begin
                priority if (w_found || (r_idx == LAST)) begin
                    if (w_out_free) begin
                        w_load_out = 1'b1;
                        n_state    = ST_IDLE;
                        n_status   = w_found ? STATUS_OK : STATUS_MISS;
                        n_slot     = w_found ? w_slot_ext[SLOT_W-1:0] : '0;
                    end
                end else begin
                    w_ctl.sh_match = 1'b1;
                    n_idx          = r_idx + 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_occ = w_occ_ext[OCC_W-1:0];
        if (w_load_out) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_action <= i_req.action;
            r_key    <= i_req.value;
        end
        r_min <= n_min;
        r_max <= n_max;
        r_idx <= n_idx;
        if (w_load_out) begin
            r_status <= n_status;
            r_slot   <= n_slot;
            r_occ    <= n_occ;
        end
    end

endmodule

@@ design/srins_chk.sv @@
// port-level checks for the sorted ring block, bound to the top level
module srins_chk import srins_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_req_valid,
    input logic                 i_req_ready,
    input logic                 i_rsp_valid,
    input logic                 i_rsp_ready,
    input logic [STATUS_W-1:0]  i_rsp_status,
    input logic [SLOT_W-1:0]    i_rsp_slot,
    input logic [OCC_W-1:0]     i_rsp_occupancy
);

    // a stalled response holds its payload
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_rsp_status)
            && $stable(i_rsp_slot) && $stable(i_rsp_occupancy)))
        else $error("response changed while stalled");

    // one request in flight at a time
    a_req_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request taken while busy");

    // a rejected insert only happens on a full table
    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && (i_rsp_status == STATUS_FULL)) |-> (i_rsp_occupancy == OCC_W'(CAPACITY)))
        else $error("full status with wrong occupancy");

    // slot index is zero unless a key was found
    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && (i_rsp_status != STATUS_OK)) |-> (i_rsp_slot == '0))
        else $error("nonzero slot without a hit");

    // occupancy never exceeds the ring size
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> ((CAPACITY > 31) || (32'(i_rsp_occupancy) <= CAPACITY)))
        else $error("occupancy above capacity");

endmodule

bind sorted_ring_insert_search_top srins_chk #(
    .CAPACITY (CAPACITY)
) u_srins_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_req_valid     (i_req.valid),
    .i_req_ready     (i_req.ready),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_rsp_status    (o_rsp.status),
    .i_rsp_slot      (o_rsp.slot),
    .i_rsp_occupancy (o_rsp.occupancy)
);
